### hdl/fdcsl_pkg.sv
// Package for the framed drive command slew limiter.
// Field types, frame marks, register indexes and reset values.
// No dependencies.
`default_nettype none

package fdcsl_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [7:0]  position_type;
   typedef logic [15:0] ticks_type;
   typedef logic [1:0]  reg_index_type;
   typedef logic [15:0] reg_data_type;
   typedef logic [1:0]  byte_pos_type;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   localparam byte_type START_MARK = 8'h3C;
   localparam byte_type END_MARK   = 8'h3E;

   localparam ticks_type ELAPSED_MAX = 16'hFFFF;

   localparam byte_pos_type POS_START = 2'd0;
   localparam byte_pos_type POS_LEFT  = 2'd1;
   localparam byte_pos_type POS_RIGHT = 2'd2;
   localparam byte_pos_type POS_END   = 2'd3;

   localparam reg_index_type REG_RAMP_STEP     = 2'd0;
   localparam reg_index_type REG_TIMEOUT_TICKS = 2'd1;
   localparam reg_index_type REG_NEUTRAL_POS   = 2'd2;

   localparam position_type RAMP_STEP_RESET = 8'd10;
   localparam ticks_type    TIMEOUT_RESET   = 16'd50;
   localparam position_type NEUTRAL_RESET   = 8'd127;

endpackage

`default_nettype wire

### hdl/fdcsl_if.sv
// Channel interfaces: input items, result items and register writes.
// Depends on fdcsl_pkg.
`default_nettype none

interface fdcsl_req_if;
   logic                valid;
   logic                ready;
   logic                kind;
   fdcsl_pkg::byte_type rx_byte;

   modport source (output valid, output kind, output rx_byte, input ready);
   modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface fdcsl_rsp_if;
   logic                    valid;
   logic                    ready;
   fdcsl_pkg::position_type left_position;
   fdcsl_pkg::position_type right_position;
   logic                    is_failsafe;

   modport source (output valid, output left_position, output right_position,
                   output is_failsafe, input ready);
   modport sink   (input valid, input left_position, input right_position,
                   input is_failsafe, output ready);
endinterface

interface fdcsl_csr_if;
   logic                     valid;
   logic                     ready;
   fdcsl_pkg::reg_index_type index;
   fdcsl_pkg::reg_data_type  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/fdcsl_slew.sv
// One wheel's slew step: moves a position toward its target by at most the ramp step.
// Depends on fdcsl_pkg.
`default_nettype none

module fdcsl_slew (
   input  fdcsl_pkg::position_type pos,
   input  fdcsl_pkg::position_type goal,
   input  fdcsl_pkg::position_type step,
   output fdcsl_pkg::position_type next_pos
);
   import fdcsl_pkg::*;

   logic [8:0] up_sum;
   logic [8:0] goal_plus;

   assign up_sum    = {1'b0, pos} + {1'b0, step};
   assign goal_plus = {1'b0, goal} + {1'b0, step};

   always_comb begin
      if (pos < goal) begin
         next_pos = (up_sum < {1'b0, goal}) ? up_sum[7:0] : goal;
      end else if ({1'b0, pos} > goal_plus) begin
         next_pos = pos - step;
      end else begin
         next_pos = goal;
      end
   end

endmodule

`default_nettype wire

### hdl/framed_drive_command_slew_limiter_unit.sv
// Top level: frame receiver, slew-limited wheel positions and link-loss failsafe.
// Depends on fdcsl_pkg, fdcsl_if and fdcsl_slew.
//
//   channel   role     payload
//   req_ch    sink     kind, rx_byte
//   rsp_ch    source   left_position, right_position, is_failsafe
//   csr_ch    sink     index, data (always ready)
//
// An item is registered at acceptance and processed once the output register can advance,
// writing its result, if any, into the output register: one item per cycle.
// The output register holds a result until taken; input stalls only then.
// Reset is synchronous and restores flags, config and state, not data registers.
`default_nettype none

module framed_drive_command_slew_limiter_unit (
   input wire logic    clock,
   input wire logic    reset,
   fdcsl_req_if.sink   req_ch,
   fdcsl_rsp_if.source rsp_ch,
   fdcsl_csr_if.sink   csr_ch
);
   import fdcsl_pkg::*;

   // configuration
   position_type ramp_step_ff;
   ticks_type    timeout_ff;
   position_type neutral_ff;

   // input register
   logic     in_valid_ff;
   logic     in_kind_ff;
   byte_type in_byte_ff;

   // block state
   byte_pos_type byte_index_ff, byte_index_in;
   logic         starts_ok_ff, starts_ok_in;
   position_type left_target_ff, left_target_in;
   position_type right_target_ff, right_target_in;
   logic         hunting_ff, hunting_in;
   position_type left_wheel_ff, left_wheel_in;
   position_type right_wheel_ff, right_wheel_in;
   ticks_type    elapsed_ff, elapsed_in;

   // output register
   logic         out_valid_ff;
   position_type out_left_ff, out_right_ff;
   logic         out_failsafe_ff;

   logic         res_valid;
   position_type res_left, res_right;
   logic         res_failsafe;
   position_type left_slew, right_slew;
   ticks_type    elapsed_inc;
   logic         advance;
   logic         fire;

   assign advance = !out_valid_ff || rsp_ch.ready;
   assign fire    = in_valid_ff && advance;

   assign req_ch.ready = !in_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.left_position  = out_left_ff;
   assign rsp_ch.right_position = out_right_ff;
   assign rsp_ch.is_failsafe    = out_failsafe_ff;

   fdcsl_slew u_slew_left (
      .pos      (left_wheel_ff),
      .goal     (left_target_ff),
      .step     (ramp_step_ff),
      .next_pos (left_slew)
   );

   fdcsl_slew u_slew_right (
      .pos      (right_wheel_ff),
      .goal     (right_target_ff),
      .step     (ramp_step_ff),
      .next_pos (right_slew)
   );

   assign elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 16'd1;

   always_comb begin
      byte_index_in   = byte_index_ff;
      starts_ok_in    = starts_ok_ff;
      left_target_in  = left_target_ff;
      right_target_in = right_target_ff;
      hunting_in      = hunting_ff;
      left_wheel_in   = left_wheel_ff;
      right_wheel_in  = right_wheel_ff;
      elapsed_in      = elapsed_ff;
      res_valid       = 1'b0;
      res_left        = left_slew;
      res_right       = right_slew;
      res_failsafe    = 1'b0;
      if (in_kind_ff == KIND_TICK) begin
         elapsed_in = elapsed_inc;
         if (!hunting_ff && (elapsed_inc > timeout_ff)) begin
            res_valid    = 1'b1;
            res_left     = neutral_ff;
            res_right    = neutral_ff;
            res_failsafe = 1'b1;
         end
      end else if (hunting_ff) begin
         if (in_byte_ff == END_MARK) begin
            hunting_in    = 1'b0;
            byte_index_in = POS_START;
         end
      end else begin
         case (byte_index_ff)
            POS_START: begin
               starts_ok_in  = (in_byte_ff == START_MARK);
               byte_index_in = POS_LEFT;
            end
            POS_LEFT: begin
               left_target_in = in_byte_ff;
               byte_index_in  = POS_RIGHT;
            end
            POS_RIGHT: begin
               right_target_in = in_byte_ff;
               byte_index_in   = POS_END;
            end
            default: begin
               byte_index_in = POS_START;
               if (starts_ok_ff) begin
                  left_wheel_in  = left_slew;
                  right_wheel_in = right_slew;
                  elapsed_in     = '0;
                  res_valid      = 1'b1;
               end else if (in_byte_ff != END_MARK) begin
                  hunting_in = 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_step_ff <= RAMP_STEP_RESET;
         timeout_ff   <= TIMEOUT_RESET;
         neutral_ff   <= NEUTRAL_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_RAMP_STEP:     ramp_step_ff <= csr_ch.data[7:0];
            REG_TIMEOUT_TICKS: timeout_ff   <= csr_ch.data;
            REG_NEUTRAL_POS:   neutral_ff   <= csr_ch.data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_kind_ff <= req_ch.kind;
         in_byte_ff <= req_ch.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff   <= POS_START;
         starts_ok_ff    <= 1'b0;
         left_target_ff  <= '0;
         right_target_ff <= '0;
         hunting_ff      <= 1'b0;
         left_wheel_ff   <= NEUTRAL_RESET;
         right_wheel_ff  <= NEUTRAL_RESET;
         elapsed_ff      <= '0;
      end else if (fire) begin
         byte_index_ff   <= byte_index_in;
         starts_ok_ff    <= starts_ok_in;
         left_target_ff  <= left_target_in;
         right_target_ff <= right_target_in;
         hunting_ff      <= hunting_in;
         left_wheel_ff   <= left_wheel_in;
         right_wheel_ff  <= right_wheel_in;
         elapsed_ff      <= elapsed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire && res_valid) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && res_valid) begin
         out_left_ff     <= res_left;
         out_right_ff    <= res_right;
         out_failsafe_ff <= res_failsafe;
      end
   end

endmodule

`default_nettype wire

### hdl/fdcsl_checker.sv
// Port-level checks for the slew limiter top level, attached by bind.
// Depends on fdcsl_pkg and framed_drive_command_slew_limiter_unit.
`default_nettype none

module fdcsl_checker (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_ready,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire fdcsl_pkg::position_type rsp_left_position,
   input wire fdcsl_pkg::position_type rsp_right_position,
   input wire logic                    rsp_is_failsafe
);
   import fdcsl_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_left_position)
         && $stable(rsp_right_position) && $stable(rsp_is_failsafe))
      else $error("stalled result item changed");

   a_failsafe_neutral: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_failsafe |-> rsp_left_position == rsp_right_position)
      else $error("failsafe item with unequal positions");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

endmodule

bind framed_drive_command_slew_limiter_unit fdcsl_checker u_fdcsl_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_left_position  (rsp_ch.left_position),
   .rsp_right_position (rsp_ch.right_position),
   .rsp_is_failsafe    (rsp_ch.is_failsafe)
);

`default_nettype wire
